// File: hdl/tone_waveform_synthesizer_defines.svh
// Assertion macros used by the checker file
`ifndef TONE_WAVEFORM_SYNTHESIZER_DEFINES_SVH
`define TONE_WAVEFORM_SYNTHESIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TWS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tws assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tws assertion failed");

`endif

// File: hdl/tws_pkg.sv
package tws_pkg;

  // Quarter-wave sine table geometry
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_ENTRIES    = (1 << SINE_TABLE_BITS) + 1;
  localparam int unsigned SINE_MAG_W      = 15;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;

  localparam logic [31:0] NOISE_SEED = 32'hACE1_ACE1;
  localparam logic [31:0] NOISE_MASK = 32'h8020_0003;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    WAVE_SINE    = 3'd0,
    WAVE_SQUARE  = 3'd1,
    WAVE_SAW     = 3'd2,
    WAVE_NOISE   = 3'd3,
    WAVE_IMPULSE = 3'd4,
    WAVE_SILENCE = 3'd5
  } wave_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WAVEFORM     = 3'd0,
    REG_PHASE_STEP   = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_GAIN         = 3'd3,
    REG_START_SAMPLE = 3'd4,
    REG_SAMPLE_COUNT = 3'd5,
    REG_GATE_PERIOD  = 3'd6
  } cfg_reg_e;

  typedef logic [SINE_MAG_W-1:0] sine_table_t [SINE_ENTRIES];

  // Payload after the input register
  typedef struct packed {
    logic signed [15:0] mix;
    logic [31:0]        phase;
    logic [31:0]        prev;
    logic signed [15:0] noise;
    logic               on;
  } tws_stage_a_t;

  // Payload after waveform decode
  typedef struct packed {
    logic signed [15:0] mix;
    logic signed [15:0] amp;
    logic               use_sine;
    logic               on;
  } tws_stage_b_t;

  // Payload after the gain multiply
  typedef struct packed {
    logic signed [15:0] mix;
    logic signed [33:0] prod;
    logic               on;
  } tws_stage_c_t;

  // One quarter-wave entry: Horner series of sin(x), Q30, rounded to Q15
  function automatic logic [SINE_MAG_W-1:0] quarter_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned a;
    x  = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    a  = (s * 64'd32767 + 64'd536870912) >> 30;
    if (a > 64'd32767) begin
      a = 64'd32767;
    end
    return a[SINE_MAG_W-1:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
      tbl[k] = quarter_entry(k);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// File: hdl/tws_sine_rom.sv
module tws_sine_rom (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [15:0] sine_o
);
  import tws_pkg::*;

  localparam logic [SINE_TABLE_BITS:0] SINE_FULL = {1'b1, {SINE_TABLE_BITS{1'b0}}};

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   addr;
  logic [SINE_MAG_W-1:0]      mag_q;
  logic                       neg_q;

  // Fold the phase onto the first quadrant
  assign idx  = phase_i[29 -: SINE_TABLE_BITS];
  assign addr = phase_i[30] ? (SINE_FULL - {1'b0, idx}) : {1'b0, idx};

  // Registered table read, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= SINE_TABLE[addr];
      neg_q <= phase_i[31];
    end
  end

  // Second half of the cycle is negative
  assign sine_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// File: hdl/tone_waveform_synthesizer.sv
// Channel      | Direction | Payload (low bit first)
// s_axis       | in        | tdata[15:0] mix_in
// m_axis       | out       | tdata[15:0] sample_out, tuser[0] tone_active
// cfg          | in        | write only: cfg_we_i, cfg_addr_i, cfg_wdata_i
//
// One sample is taken per cycle unless a full pipeline drops s_axis_tready.
// The path has four register stages: sample state, waveform and sine
// table read, gain multiply, output add. Only the oscillator state registers
// (index, phase, gate, noise) feed back.
// rst_ni resets stage valids, oscillator state and the configuration registers.
// A stall on m_axis holds the output; earlier stages keep filling until all are full.
module tone_waveform_synthesizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] mix_in
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]                      m_axis_tuser,   // [0] tone_active
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [tws_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [tws_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tws_pkg::*;

  // Configuration registers
  logic [2:0]  waveform_q;
  logic [31:0] phase_step_q;
  logic [31:0] phase_offset_q;
  logic [15:0] gain_q;
  logic [31:0] start_sample_q;
  logic [31:0] sample_count_q;
  logic [31:0] gate_period_q;

  // Oscillator state
  logic [31:0] sample_index_q;
  logic [31:0] phase_product_q;
  logic [31:0] previous_phase_q;
  logic        gate_on_q, gate_on_d;
  logic [31:0] gate_counter_q, gate_counter_d;
  logic [31:0] noise_q, noise_d;

  // Pipeline
  logic         va_q, vb_q, vc_q, vo_q;
  logic         en_a, en_b, en_c, en_o, s_fire;
  tws_stage_a_t sa_d, sa_q;
  tws_stage_b_t sb_d, sb_q;
  tws_stage_c_t sc_d, sc_q;
  logic signed [15:0] sine_amp;
  logic signed [15:0] amp_c;
  logic signed [33:0] tone_c;
  logic [15:0]  sample_d, sample_q;
  logic         active_q;

  logic [31:0] phase;
  logic [31:0] rel_index;
  logic        in_window;
  logic        gate_val;
  logic [32:0] counter_inc;

  // A stage loads when it is empty or its contents move on
  assign en_o          = !vo_q || m_axis_tready;
  assign en_c          = !vc_q || en_o;
  assign en_b          = !vb_q || en_c;
  assign en_a          = !va_q || en_b;
  assign s_axis_tready = en_a;
  assign s_fire        = s_axis_tvalid && en_a;

  // Configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q     <= WAVE_SILENCE;
      phase_step_q   <= '0;
      phase_offset_q <= '0;
      gain_q         <= '0;
      start_sample_q <= '0;
      sample_count_q <= '0;
      gate_period_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WAVEFORM:     waveform_q     <= cfg_wdata_i[2:0];
        REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i;
        REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata_i;
        REG_GAIN:         gain_q         <= cfg_wdata_i[15:0];
        REG_START_SAMPLE: start_sample_q <= cfg_wdata_i;
        REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i;
        REG_GATE_PERIOD:  gate_period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window, gate, noise and phase for the incoming sample
  always_comb begin
    phase     = phase_offset_q + phase_product_q;
    rel_index = sample_index_q - start_sample_q;
    in_window = (sample_index_q >= start_sample_q) &&
                ((sample_count_q == '0) || (rel_index < sample_count_q));

    gate_val = gate_on_q;
    if (in_window) begin
      if (sample_index_q == start_sample_q) begin
        gate_val = 1'b1;
      end
      if ((gate_period_q != '0) && (sample_index_q != '0) && (gate_counter_q == '0)) begin
        gate_val = !gate_val;
      end
    end
    gate_on_d = gate_val;

    counter_inc = {1'b0, gate_counter_q} + 33'd1;
    if (gate_period_q == '0) begin
      gate_counter_d = '0;
    end else if (counter_inc >= {1'b0, gate_period_q}) begin
      gate_counter_d = '0;
    end else begin
      gate_counter_d = counter_inc[31:0];
    end

    // Galois LFSR steps only on in-window noise samples
    noise_d = noise_q;
    if (in_window && (waveform_q == WAVE_NOISE)) begin
      noise_d = noise_q[0] ? ({1'b0, noise_q[31:1]} ^ NOISE_MASK) : {1'b0, noise_q[31:1]};
    end

    sa_d.mix   = $signed(s_axis_tdata);
    sa_d.phase = phase;
    sa_d.prev  = (sample_index_q == '0) ? (phase_offset_q - phase_step_q) : previous_phase_q;
    sa_d.noise = $signed(noise_d[15:0]);
    sa_d.on    = in_window && ((gate_period_q == '0) || gate_val);
  end

  // Oscillator state advances once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q   <= '0;
      phase_product_q  <= '0;
      previous_phase_q <= '0;
      gate_on_q        <= 1'b1;
      gate_counter_q   <= '0;
      noise_q          <= NOISE_SEED;
    end else if (s_fire) begin
      sample_index_q   <= sample_index_q + 32'd1;
      phase_product_q  <= phase_product_q + phase_step_q;
      previous_phase_q <= phase;
      gate_on_q        <= gate_on_d;
      gate_counter_q   <= gate_counter_d;
      noise_q          <= noise_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= s_axis_tvalid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_o) vo_q <= vc_q;
    end
  end

  // Waveform decode; an inactive sample gets zero amplitude
  always_comb begin
    sb_d.mix      = sa_q.mix;
    sb_d.on       = sa_q.on;
    sb_d.use_sine = 1'b0;
    sb_d.amp      = '0;
    case (waveform_q)
      WAVE_SINE:    sb_d.use_sine = 1'b1;
      WAVE_SQUARE:  sb_d.amp = sa_q.phase[31] ? -16'sd32767 : 16'sd32767;
      WAVE_SAW:     sb_d.amp = $signed({~sa_q.phase[31], sa_q.phase[30:16]});
      WAVE_NOISE:   sb_d.amp = sa_q.noise;
      WAVE_IMPULSE: sb_d.amp = (sa_q.prev > sa_q.phase) ? 16'sd32767 : 16'sd0;
      default:      sb_d.amp = '0;
    endcase
    if (!sa_q.on) begin
      sb_d.use_sine = 1'b0;
      sb_d.amp      = '0;
    end
  end

  tws_sine_rom u_sine_rom (
    .clk_i   (clk_i),
    .en_i    (en_b),
    .phase_i (sa_q.phase),
    .sine_o  (sine_amp)
  );

  // Gain multiply
  always_comb begin
    amp_c      = sb_q.use_sine ? sine_amp : sb_q.amp;
    sc_d.mix   = sb_q.mix;
    sc_d.on    = sb_q.on;
    sc_d.prod  = $signed({{18{1'b0}}, gain_q}) * $signed({{18{amp_c[15]}}, amp_c});
  end

  // Scale by 2^-15 toward zero, then wrap into the mix
  always_comb begin
    tone_c   = sc_q.prod[33] ? ((sc_q.prod + 34'sd32767) >>> 15) : (sc_q.prod >>> 15);
    sample_d = sc_q.mix + tone_c[15:0];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_a) sa_q <= sa_d;
    if (en_b) sb_q <= sb_d;
    if (en_c) sc_q <= sc_d;
    if (en_o) begin
      sample_q <= sample_d;
      active_q <= sc_q.on;
    end
  end

  assign m_axis_tvalid   = vo_q;
  assign m_axis_tdata    = sample_q;
  assign m_axis_tuser[0] = active_q;

endmodule

// File: hdl/tws_checker.sv
`include "tone_waveform_synthesizer_defines.svh"

module tws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result stays put
  `TWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // With no result waiting the pipeline cannot be full
  `TWS_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // A transfer in leads to a valid output while the sink keeps taking results
  `TWS_ASSERT_NEXT(a_latency, clk_i, rst_ni,
                   in_xfer ##1 m_axis_tready ##1 m_axis_tready,
                   ##1 m_axis_tvalid)

endmodule

bind tone_waveform_synthesizer tws_checker u_tws_checker (.*);
